[rtl/base64url_decoder_unpadded_macros.svh]
`ifndef BASE64URL_DECODER_UNPADDED_MACROS_SVH
`define BASE64URL_DECODER_UNPADDED_MACROS_SVH

// check a property every clock outside reset
`define B64U_ASSERT(name, clock, rstn, prop) \
	name: assert property (@(posedge clock) disable iff (!rstn) (prop)) \
		else $error("b64u assertion failed");

// check that a condition implies a consequence on the following clock
`define B64U_ASSERT_NEXT(name, clock, rstn, cond, conseq) \
	name: assert property (@(posedge clock) disable iff (!rstn) (cond) |=> (conseq)) \
		else $error("b64u assertion failed");

`endif

[rtl/b64u_pkg.sv]
package b64u_pkg;

	localparam int unsigned SymDash       = 62;
	localparam int unsigned SymUnderscore = 63;
	localparam int unsigned SymDigitBase  = 52;
	localparam int unsigned SymLowerBase  = 26;

	localparam logic [1:0] POS_FIRST  = 2'd0;
	localparam logic [1:0] POS_SECOND = 2'd1;
	localparam logic [1:0] POS_THIRD  = 2'd2;
	localparam logic [1:0] POS_FOURTH = 2'd3;

	localparam int unsigned QueueDepth = 4;
	localparam int unsigned QueueAw    = $clog2(QueueDepth);
	localparam int unsigned QueueCw    = $clog2(QueueDepth + 1);

	typedef struct packed {
		logic [5:0] sextet;
		logic [1:0] pos;
		logic       last;
		logic       lerr;
	} entry_t;

	function automatic logic [5:0] sextet_of(input logic [7:0] c);
		logic [5:0] v;
		v = 6'd0;
		if (c >= 8'h41 && c <= 8'h5a) begin
			v = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7a) begin
			v = 6'(c - 8'h61 + 8'(SymLowerBase));
		end else if (c >= 8'h30 && c <= 8'h39) begin
			v = 6'(c - 8'h30 + 8'(SymDigitBase));
		end else if (c == 8'h2d) begin
			v = 6'(SymDash);
		end else if (c == 8'h5f) begin
			v = 6'(SymUnderscore);
		end
		return v;
	endfunction

endpackage

[rtl/b64u_front.sv]
`include "base64url_decoder_unpadded_macros.svh"

module b64u_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [7:0]          in_char,
	input  logic                in_last,
	input  logic                q_full,
	output logic                in_ready,
	output logic                push,
	output b64u_pkg::entry_t    push_entry
);
	import b64u_pkg::*;

	logic [1:0] pos_q;
	logic       seen_q;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		push_entry.sextet = sextet_of(in_char);
		push_entry.pos    = pos_q;
		push_entry.last   = in_last;
		push_entry.lerr   = in_last && !seen_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= POS_FIRST;
			seen_q <= 1'b0;
		end else if (push) begin
			if (in_last) begin
				pos_q  <= POS_FIRST;
				seen_q <= 1'b0;
			end else begin
				pos_q  <= pos_q + 2'd1;
				seen_q <= 1'b1;
			end
		end
	end

	`B64U_ASSERT_NEXT(a_stream_end_resets, clk, arst_n, push && in_last, pos_q == POS_FIRST && !seen_q)
	`B64U_ASSERT(a_pos_implies_seen, clk, arst_n, pos_q == POS_FIRST || seen_q)

endmodule

[rtl/b64u_queue.sv]
`include "base64url_decoder_unpadded_macros.svh"

module b64u_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  b64u_pkg::entry_t    push_entry,
	output logic                full,
	input  logic                pop,
	output logic                not_empty,
	output b64u_pkg::entry_t    pop_entry
);
	import b64u_pkg::*;

	entry_t               mem_q [QueueDepth];
	logic [QueueAw-1:0]   wr_ptr_q;
	logic [QueueAw-1:0]   rd_ptr_q;
	logic [QueueCw-1:0]   count_q;

	assign full      = count_q == QueueCw'(QueueDepth);
	assign not_empty = count_q != '0;
	assign pop_entry = mem_q[rd_ptr_q];

	function automatic logic [QueueAw-1:0] next_ptr(input logic [QueueAw-1:0] p);
		return (p == QueueAw'(QueueDepth - 1)) ? '0 : p + QueueAw'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QueueCw'(1);
				2'b01:   count_q <= count_q - QueueCw'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`B64U_ASSERT(a_no_overflow, clk, arst_n, !(push && full))
	`B64U_ASSERT(a_no_underflow, clk, arst_n, !(pop && !not_empty))
	`B64U_ASSERT(a_count_bound, clk, arst_n, count_q <= QueueCw'(QueueDepth))

endmodule

[rtl/b64u_back.sv]
module b64u_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_not_empty,
	input  b64u_pkg::entry_t    q_entry,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_byte,
	output logic                out_byte_valid,
	output logic                out_done,
	output logic                out_lerr
);
	import b64u_pkg::*;

	logic [5:0] pending_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       bvalid_q;
	logic       done_q;
	logic       lerr_q;

	logic [7:0] byte_d;
	logic       bvalid_d;
	logic [5:0] pending_d;
	logic [5:0] v;

	assign pop = q_not_empty && (!valid_q || out_ready);
	assign v   = q_entry.sextet;

	always_comb begin
		case (q_entry.pos)
			POS_FIRST: begin
				byte_d    = 8'd0;
				bvalid_d  = 1'b0;
				pending_d = v;
			end
			POS_SECOND: begin
				byte_d    = {pending_q, v[5:4]};
				bvalid_d  = 1'b1;
				pending_d = {2'b00, v[3:0]};
			end
			POS_THIRD: begin
				byte_d    = {pending_q[3:0], v[5:2]};
				bvalid_d  = 1'b1;
				pending_d = {4'b0000, v[1:0]};
			end
			default: begin
				byte_d    = {pending_q[1:0], v};
				bvalid_d  = 1'b1;
				pending_d = 6'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			pending_q <= 6'd0;
		end else begin
			if (pop) begin
				valid_q   <= 1'b1;
				pending_q <= q_entry.last ? 6'd0 : pending_d;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			byte_q   <= byte_d;
			bvalid_q <= bvalid_d;
			done_q   <= q_entry.last;
			lerr_q   <= q_entry.lerr;
		end
	end

	assign out_valid      = valid_q;
	assign out_byte       = byte_q;
	assign out_byte_valid = bvalid_q;
	assign out_done       = done_q;
	assign out_lerr       = lerr_q;

endmodule

[rtl/base64url_decoder_unpadded.sv]
// Streaming base64url decoder without padding. Each input word carries one ASCII
// character in tdata and marks the last character of a stream with tlast; each
// input word yields exactly one output word carrying a decoded byte in tdata,
// a byte-valid flag and a one-character-stream error flag in tuser, and tlast
// echoed from the input. Characters outside the alphabet decode as zero. The
// block accepts one character per clock while the queue is not full; a
// character passes the front classifier, a four-entry queue and the output
// register of the bit-assembly stage, and the queue write and that output
// register are the registers that lie between acceptance and the output.
// The queue absorbs output stalls so the input keeps flowing until it fills.
`include "base64url_decoder_unpadded_macros.svh"

module base64url_decoder_unpadded (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_char
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic [1:0] m_axis_tuser,   // [0] byte_valid, [1] length_error
	output logic       m_axis_tlast
);
	import b64u_pkg::*;

	logic   push;
	entry_t push_entry;
	logic   q_full;
	logic   pop;
	logic   q_not_empty;
	entry_t pop_entry;
	logic   byte_valid;
	logic   length_error;

	b64u_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_char    (s_axis_tdata),
		.in_last    (s_axis_tlast),
		.q_full     (q_full),
		.in_ready   (s_axis_tready),
		.push       (push),
		.push_entry (push_entry)
	);

	b64u_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.not_empty  (q_not_empty),
		.pop_entry  (pop_entry)
	);

	b64u_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_not_empty    (q_not_empty),
		.q_entry        (pop_entry),
		.pop            (pop),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_byte       (m_axis_tdata),
		.out_byte_valid (byte_valid),
		.out_done       (m_axis_tlast),
		.out_lerr       (length_error)
	);

	assign m_axis_tuser = {length_error, byte_valid};

	`B64U_ASSERT(a_lerr_on_last, clk, arst_n, !(m_axis_tvalid && length_error) || m_axis_tlast)
	`B64U_ASSERT(a_lerr_no_byte, clk, arst_n, !(m_axis_tvalid && length_error) || !byte_valid)

endmodule

[sim/base64url_decoder_unpadded_tb.sv]
`timescale 1ns / 1ps

module base64url_decoder_unpadded_tb;

	import b64u_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int MAX_GAP     = 12;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       done;
		logic       lerr;
	} dec_word_t;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata  = 8'd0;
	logic       s_axis_tlast  = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic       m_axis_tlast;

	logic [5:0] sextet_lut [256];
	logic [7:0] alphabet [64];

	logic [1:0] grp_pos;
	logic [5:0] held_bits;
	logic       char_seen;

	dec_word_t  decoded_q [$];
	int         mismatch_count = 0;
	int         cycle_count    = 0;
	bit         src_idle       = 1'b1;
	bit         snk_idle       = 1'b1;
	int         stall_left     = 0;

	base64url_decoder_unpadded uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic dec_word_t decode_char(input logic [7:0] c, input logic last);
		dec_word_t  w;
		logic [5:0] v;
		v       = sextet_lut[c];
		w       = '0;
		w.done  = last;
		w.lerr  = last && !char_seen;
		case (grp_pos)
			POS_FIRST: begin
				held_bits = v;
			end
			POS_SECOND: begin
				w.data    = {held_bits, v[5:4]};
				w.valid   = 1'b1;
				held_bits = {2'b00, v[3:0]};
			end
			POS_THIRD: begin
				w.data    = {held_bits[3:0], v[5:2]};
				w.valid   = 1'b1;
				held_bits = {4'b0000, v[1:0]};
			end
			default: begin
				w.data    = {held_bits[1:0], v};
				w.valid   = 1'b1;
				held_bits = 6'd0;
			end
		endcase
		grp_pos   = grp_pos + 2'd1;
		char_seen = 1'b1;
		if (last) begin
			grp_pos   = POS_FIRST;
			held_bits = 6'd0;
			char_seen = 1'b0;
		end
		return w;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// hold the word until the handshake, then leave tvalid up for the next one
	task automatic send_char(input logic [7:0] c, input logic last);
		int gap;
		gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		decoded_q.push_back(decode_char(c, last));
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (decoded_q.size() != 0);
	endtask

	function automatic logic [7:0] pick_char(input int noise_pct);
		if ($urandom_range(0, 99) < noise_pct)
			return 8'($urandom_range(0, 255));
		return alphabet[$urandom_range(0, 63)];
	endfunction

	task automatic send_stream(input int len, input int noise_pct);
		for (int i = 0; i < len; i++)
			send_char(pick_char(noise_pct), i == len - 1);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left    <= 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			int stall;
			dec_word_t want;
			if (decoded_q.size() == 0) begin
				report_mismatch("unexpected word", m_axis_tdata, 0);
			end else begin
				want = decoded_q.pop_front();
				if (m_axis_tdata !== want.data)
					report_mismatch("out_byte", m_axis_tdata, want.data);
				if (m_axis_tuser[0] !== want.valid)
					report_mismatch("byte_valid", m_axis_tuser[0], want.valid);
				if (m_axis_tlast !== want.done)
					report_mismatch("stream_done", m_axis_tlast, want.done);
				if (m_axis_tuser[1] !== want.lerr)
					report_mismatch("length_error", m_axis_tuser[1], want.lerr);
			end
			stall = snk_idle ? $urandom_range(0, MAX_GAP) : 0;
			stall_left    <= stall;
			m_axis_tready <= (stall == 0);
		end else if (stall_left > 0) begin
			stall_left    <= stall_left - 1;
			m_axis_tready <= (stall_left == 1);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic test_directed();
		logic [7:0] edge_chars [8];
		edge_chars = '{8'h41, 8'h5a, 8'h61, 8'h7a, 8'h30, 8'h39, 8'h2d, 8'h5f};
		// one-character stream
		send_char(8'h5f, 1'b1);
		// two full groups over the alphabet edges, then a lone trailing character
		foreach (edge_chars[i])
			send_char(edge_chars[i], 1'b0);
		send_char(8'h00, 1'b1);
		// trailing group of three, all outside the alphabet
		send_char(8'hff, 1'b0);
		send_char(8'h2b, 1'b0);
		send_char(8'h2f, 1'b1);
		// trailing group of two
		send_char(8'h3d, 1'b0);
		send_char(8'h7b, 1'b1);
		// full group at the stream end, neighbors of the alphabet ranges
		send_char(8'h40, 1'b0);
		send_char(8'h5b, 1'b0);
		send_char(8'h60, 1'b0);
		send_char(8'h3a, 1'b1);
		send_char(8'h80, 1'b1);
		wait_drained();
	endtask

	task automatic test_random_streams();
		int sent;
		int len;
		int sel;
		sent = 0;
		for (int s = 0; sent < 800; s++) begin
			sel = $urandom_range(0, 99);
			if (sel < 25)
				len = $urandom_range(1, 4);
			else if (sel < 85)
				len = $urandom_range(5, 16);
			else
				len = $urandom_range(17, 60);
			src_idle = ($urandom_range(0, 3) != 0);
			snk_idle = ($urandom_range(0, 3) != 0);
			send_stream(len, 10);
			sent += len;
			if (s % 20 == 19)
				wait_drained();
		end
	endtask

	// arbitrary bytes with tlast at random, first back to back on both sides, then with random gaps
	task automatic test_noise();
		src_idle = 1'b0;
		snk_idle = 1'b0;
		for (int i = 0; i < 100; i++)
			send_char(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
		src_idle = 1'b1;
		snk_idle = 1'b1;
		for (int i = 0; i < 100; i++)
			send_char(8'($urandom_range(0, 255)), (i == 99) || ($urandom_range(0, 5) == 0));
	endtask

	initial begin
		for (int i = 0; i < 256; i++)
			sextet_lut[i] = 6'd0;
		for (int i = 0; i < 26; i++) begin
			alphabet[i]                 = 8'h41 + 8'(i);
			alphabet[i + SymLowerBase]  = 8'h61 + 8'(i);
		end
		for (int i = 0; i < 10; i++)
			alphabet[i + SymDigitBase] = 8'h30 + 8'(i);
		alphabet[SymDash]       = 8'h2d;
		alphabet[SymUnderscore] = 8'h5f;
		for (int i = 0; i < 64; i++)
			sextet_lut[alphabet[i]] = 6'(i);
		grp_pos   = POS_FIRST;
		held_bits = 6'd0;
		char_seen = 1'b0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_streams();
		test_noise();

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && decoded_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
